// ----- sv/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Shared types and constants for the receive-side frame parser.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // Header bit and length code values.
    localparam logic [7:0] FIN_BIT   = 8'h80;
    localparam logic [6:0] LEN_MASK  = 7'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [15:0] KEY_BYTES = 16'd4;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_LEN    = 3'd1,
        PH_EXT_HI = 3'd2,
        PH_EXT_LO = 3'd3,
        PH_KEY    = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    // One result item.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        status_t    status;
        logic       last;
    } result_t;

endpackage

// ----- sv/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one frame per received buffer, one byte per cycle while in_stall is
// low, and emits the unmasked payload bytes with the frame type and a last flag.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall  | data_byte, buffer_start
//  out     | output    | out_valid/out_stall| payload_byte, frame_type, status, last
//
//  One byte is accepted every cycle while in_stall is low; each header or payload
//  step is a single registered pass from the input byte to the result, which lands
//  in the output register, or in the skid register while the output is held.
//  A skid register behind the output keeps the input moving while a result
//  waits; in_stall rises only once that skid register holds a result.
//  rst_n clears the parser to the skipping phase and empties both registers.
//
// The parser keeps the first byte of a buffer as the frame type when its FIN
// bit is set, otherwise it ignores the buffer until the next buffer start.
// The second byte carries the mask bit and a 7-bit length code. Code 126 is
// followed by a 16-bit big-endian length; code 127 is not supported, and the
// frame is reported with the dropped status and abandoned. A masked frame
// then carries a four-byte key, and each payload byte is XORed with the key
// byte selected by its index modulo four. A frame of zero length yields a
// single empty-frame marker. Bytes past the end of the payload are ignored.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       buffer_start,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_type,
    output logic [1:0] status,
    output logic       last
);

    // Parser state.
    wsdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       type_byte_reg, type_byte_next;
    logic             masked_flag_reg, masked_flag_next;
    logic [15:0]      payload_length_reg, payload_length_next;
    logic [15:0]      byte_count_reg, byte_count_next;
    logic [31:0]      mask_key_reg, mask_key_next;

    // Output register and skid register.
    logic               out_valid_reg, out_valid_next;
    wsdf_pkg::result_t  out_data_reg, out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    wsdf_pkg::result_t  skid_data_reg, skid_data_next;

    // Result of the current request.
    logic              res_valid;
    wsdf_pkg::result_t res;

    logic        accept;
    logic        out_free;
    logic [6:0]  len_code;
    logic [15:0] hdr_len;
    logic        hdr_masked;
    logic        hdr_done;
    logic [15:0] count_inc;
    logic [7:0]  key_byte;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign len_code  = data_byte[6:0] & wsdf_pkg::LEN_MASK;
    assign count_inc = byte_count_reg + 16'd1;

    // Key byte for the current payload index; index zero takes the top byte.
    always_comb
    begin
        unique case (byte_count_reg[1:0])
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // Next parser state and the result of this request.
    always_comb
    begin
        phase_next          = phase_reg;
        type_byte_next      = type_byte_reg;
        masked_flag_next    = masked_flag_reg;
        payload_length_next = payload_length_reg;
        byte_count_next     = byte_count_reg;
        mask_key_next       = mask_key_reg;

        res_valid        = 1'b0;
        res.payload_byte = 8'd0;
        res.frame_type   = type_byte_reg;
        res.status       = wsdf_pkg::ST_DATA;
        res.last         = 1'b0;

        hdr_done   = 1'b0;
        hdr_masked = masked_flag_reg;
        hdr_len    = payload_length_reg;

        if (accept)
        begin
            if (buffer_start)
            begin
                if ((data_byte & wsdf_pkg::FIN_BIT) != 8'd0)
                begin
                    type_byte_next = data_byte;
                    phase_next     = wsdf_pkg::PH_LEN;
                end
                else
                begin
                    phase_next = wsdf_pkg::PH_SKIP;
                end
            end
            else
            begin
                unique case (phase_reg)
                    wsdf_pkg::PH_LEN:
                    begin
                        masked_flag_next = data_byte[7];
                        if (len_code == wsdf_pkg::LEN_EXT16)
                        begin
                            phase_next = wsdf_pkg::PH_EXT_HI;
                        end
                        else if (len_code == wsdf_pkg::LEN_EXT64)
                        begin
                            phase_next = wsdf_pkg::PH_SKIP;
                            res_valid  = 1'b1;
                            res.status = wsdf_pkg::ST_DROPPED;
                            res.last   = 1'b1;
                        end
                        else
                        begin
                            hdr_done   = 1'b1;
                            hdr_masked = data_byte[7];
                            hdr_len    = {9'd0, len_code};
                        end
                    end
                    wsdf_pkg::PH_EXT_HI:
                    begin
                        payload_length_next = {data_byte, 8'd0};
                        phase_next          = wsdf_pkg::PH_EXT_LO;
                    end
                    wsdf_pkg::PH_EXT_LO:
                    begin
                        hdr_done = 1'b1;
                        hdr_len  = {payload_length_reg[15:8], data_byte};
                    end
                    wsdf_pkg::PH_KEY:
                    begin
                        mask_key_next   = {mask_key_reg[23:0], data_byte};
                        byte_count_next = count_inc;
                        if (count_inc >= wsdf_pkg::KEY_BYTES)
                        begin
                            byte_count_next = 16'd0;
                            if (payload_length_reg == 16'd0)
                            begin
                                phase_next = wsdf_pkg::PH_SKIP;
                                res_valid  = 1'b1;
                                res.status = wsdf_pkg::ST_EMPTY;
                                res.last   = 1'b1;
                            end
                            else
                            begin
                                phase_next = wsdf_pkg::PH_DATA;
                            end
                        end
                    end
                    wsdf_pkg::PH_DATA:
                    begin
                        byte_count_next  = count_inc;
                        res_valid        = 1'b1;
                        res.payload_byte = masked_flag_reg ? (data_byte ^ key_byte)
                                                           : data_byte;
                        res.last         = (count_inc == payload_length_reg);
                        if (count_inc == payload_length_reg)
                        begin
                            phase_next = wsdf_pkg::PH_SKIP;
                        end
                    end
                    default:
                    begin
                        phase_next = wsdf_pkg::PH_SKIP;
                    end
                endcase

                // Length known: go on to the key, the payload or the marker.
                if (hdr_done)
                begin
                    payload_length_next = hdr_len;
                    byte_count_next     = 16'd0;
                    if (hdr_masked)
                    begin
                        phase_next = wsdf_pkg::PH_KEY;
                    end
                    else if (hdr_len == 16'd0)
                    begin
                        phase_next = wsdf_pkg::PH_SKIP;
                        res_valid  = 1'b1;
                        res.status = wsdf_pkg::ST_EMPTY;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsdf_pkg::PH_DATA;
                    end
                end
            end
        end
    end

    // Output register with a skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        priority if (out_free && skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        else if (out_free)
        begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= wsdf_pkg::PH_SKIP;
            type_byte_reg      <= 8'd0;
            masked_flag_reg    <= 1'b0;
            payload_length_reg <= 16'd0;
            byte_count_reg     <= 16'd0;
            mask_key_reg       <= 32'd0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            type_byte_reg      <= type_byte_next;
            masked_flag_reg    <= masked_flag_next;
            payload_length_reg <= payload_length_next;
            byte_count_reg     <= byte_count_next;
            mask_key_reg       <= mask_key_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_data_reg.payload_byte;
    assign frame_type   = out_data_reg.frame_type;
    assign status       = out_data_reg.status;
    assign last         = out_data_reg.last;

    // The skid register only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // Markers always close their frame.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != wsdf_pkg::ST_DATA) |-> out_data_reg.last)
        else $error("empty or dropped marker without last");

    // The payload index stays below the frame length while payload flows.
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsdf_pkg::PH_DATA) |->
            (byte_count_reg < payload_length_reg))
        else $error("payload index reached the frame length");

    // At most four key bytes are collected.
    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == wsdf_pkg::PH_KEY) |-> (byte_count_reg < wsdf_pkg::KEY_BYTES))
        else $error("mask key count out of range");

endmodule

// ----- tb/tb_websocket_frame_deframer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for websocket_frame_deframer
// Feeds received buffers one byte per request and compares every result
// against a cycle-free model of the frame parser kept inside this bench.
// Both channels idle and stall at random, with one calm stretch in between.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;

    // Give up once this many cycles pass with no request moving on either side.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Cycles waited after the last expected result has been checked.
    localparam int unsigned DRAIN_CYCLES   = 10;
    // Roughly this many frame bytes form the random part.
    localparam int unsigned RANDOM_BYTES   = 750;
    // Chance, in percent, that a side idles or stalls in a given cycle.
    localparam int unsigned IDLE_PCT       = 37;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       buffer_start = 1'b0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic [1:0] status;
    logic       last;

    websocket_frame_deframer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .buffer_start (buffer_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .frame_type   (frame_type),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be offered, each packed as {buffer_start, data_byte}.
    logic [8:0]          byte_queue[$];
    // Results the parser model says must come out, oldest first.
    wsdf_pkg::result_t   expected_results[$];

    int unsigned bytes_issued = 0;
    int unsigned frame_bytes = 0;
    int unsigned frames_built = 0;
    int unsigned results_checked = 0;
    int unsigned empty_markers = 0;
    int unsigned dropped_frames = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // During this window neither side idles, so back-to-back traffic and a
    // full-rate output path are exercised as well.
    wire steady = (bytes_issued >= 300) && (bytes_issued < 480);

    // ------------------------------------------------------------------------
    // Parser model. It mirrors the frame state that the block keeps: the
    // phase, the stored type byte, the mask flag, the payload length, the
    // byte counter and the masking key.
    // ------------------------------------------------------------------------
    wsdf_pkg::phase_t fr_phase = wsdf_pkg::PH_SKIP;
    logic [7:0]  fr_type = 8'h00;
    logic        fr_masked = 1'b0;
    logic [15:0] fr_len = 16'h0000;
    logic [15:0] fr_count = 16'h0000;
    logic [31:0] fr_key = 32'h0000_0000;

    // Called when the length is known. A masked frame still needs its key;
    // an unmasked empty frame is finished right here with a marker.
    function automatic bit header_done(output wsdf_pkg::result_t res);
        res = '0;
        fr_count = '0;
        if (fr_masked)
        begin
            fr_phase = wsdf_pkg::PH_KEY;
            return 1'b0;
        end
        if (fr_len == 16'h0000)
        begin
            fr_phase = wsdf_pkg::PH_SKIP;
            res = '{payload_byte: 8'h00, frame_type: fr_type,
                    status: wsdf_pkg::ST_EMPTY, last: 1'b1};
            return 1'b1;
        end
        fr_phase = wsdf_pkg::PH_DATA;
        return 1'b0;
    endfunction

    // Advances the model by one accepted byte; returns 1 when a result is due.
    function automatic bit deframe_predict(input logic [7:0] d, input logic first,
                                           output wsdf_pkg::result_t res);
        logic [6:0] code;
        logic [7:0] plain;
        res = '0;
        // A buffer start always restarts parsing, abandoning any open frame.
        if (first)
        begin
            if ((d & wsdf_pkg::FIN_BIT) != 8'h00)
            begin
                fr_type  = d;
                fr_phase = wsdf_pkg::PH_LEN;
            end
            else
            begin
                fr_phase = wsdf_pkg::PH_SKIP;
            end
            return 1'b0;
        end
        case (fr_phase)
            wsdf_pkg::PH_LEN:
            begin
                fr_masked = d[7];
                code = d[6:0] & wsdf_pkg::LEN_MASK;
                if (code == wsdf_pkg::LEN_EXT16)
                begin
                    fr_phase = wsdf_pkg::PH_EXT_HI;
                    return 1'b0;
                end
                if (code == wsdf_pkg::LEN_EXT64)
                begin
                    fr_phase = wsdf_pkg::PH_SKIP;
                    res = '{payload_byte: 8'h00, frame_type: fr_type,
                            status: wsdf_pkg::ST_DROPPED, last: 1'b1};
                    return 1'b1;
                end
                fr_len = {9'd0, code};
                return header_done(res);
            end
            wsdf_pkg::PH_EXT_HI:
            begin
                fr_len   = {d, 8'h00};
                fr_phase = wsdf_pkg::PH_EXT_LO;
                return 1'b0;
            end
            wsdf_pkg::PH_EXT_LO:
            begin
                fr_len = {fr_len[15:8], d};
                return header_done(res);
            end
            wsdf_pkg::PH_KEY:
            begin
                fr_key   = {fr_key[23:0], d};
                fr_count = fr_count + 16'd1;
                if (fr_count >= wsdf_pkg::KEY_BYTES)
                begin
                    fr_count = '0;
                    if (fr_len == 16'h0000)
                    begin
                        fr_phase = wsdf_pkg::PH_SKIP;
                        res = '{payload_byte: 8'h00, frame_type: fr_type,
                                status: wsdf_pkg::ST_EMPTY, last: 1'b1};
                        return 1'b1;
                    end
                    fr_phase = wsdf_pkg::PH_DATA;
                end
                return 1'b0;
            end
            wsdf_pkg::PH_DATA:
            begin
                // Key byte 0 is the first key byte received, in the top bits.
                plain = d;
                if (fr_masked)
                    plain = plain ^ fr_key[8 * (3 - fr_count[1:0]) +: 8];
                fr_count = fr_count + 16'd1;
                res = '{payload_byte: plain, frame_type: fr_type,
                        status: wsdf_pkg::ST_DATA, last: (fr_count == fr_len)};
                if (fr_count == fr_len)
                    fr_phase = wsdf_pkg::PH_SKIP;
                return 1'b1;
            end
            default:
            begin
                fr_phase = wsdf_pkg::PH_SKIP;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic first, input logic [7:0] d);
        byte_queue.push_back({first, d});
    endfunction

    // Queues one frame: the type byte, the length in its short or 16-bit
    // form, the key when masked, 'sent' payload bytes and 'trail' bytes of
    // junk after the payload. Sending fewer payload bytes than 'len' leaves
    // the frame open, so the next buffer start has to abandon it.
    task automatic queue_frame(input logic [7:0] first, input bit masked,
                               input int unsigned len, input bit ext,
                               input int unsigned sent, input int unsigned trail);
        push_byte(1'b1, first);
        if (ext)
        begin
            push_byte(1'b0, {masked, wsdf_pkg::LEN_EXT16});
            push_byte(1'b0, len[15:8]);
            push_byte(1'b0, len[7:0]);
        end
        else
        begin
            push_byte(1'b0, {masked, len[6:0]});
        end
        if (masked)
            repeat (4) push_byte(1'b0, 8'($urandom));
        repeat (sent) push_byte(1'b0, 8'($urandom));
        repeat (trail) push_byte(1'b0, 8'($urandom));
        frame_bytes  += 2 + (ext ? 2 : 0) + (masked ? 4 : 0) + sent;
        frames_built += 1;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the next queued byte unless it decides to idle. A byte
    // that is being stalled stays on the bus untouched until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            data_byte    <= 8'h00;
            buffer_start <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (byte_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                {buffer_start, data_byte} <= byte_queue.pop_front();
                in_valid     <= 1'b1;
                bytes_issued <= bytes_issued + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The result side stalls at random, except in the calm window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result that leaves the block against the oldest
    // prediction, then runs the model on the request taken at this edge. A
    // result can only belong to an earlier request, so the order is safe.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        wsdf_pkg::result_t want;
        wsdf_pkg::result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{payload_byte: payload_byte, frame_type: frame_type,
                        status: wsdf_pkg::status_t'(status), last: last};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result %02h/%02h/%0d/%0b",
                                 $time, got.payload_byte, got.frame_type,
                                 got.status, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.payload_byte !== want.payload_byte
                        || got.frame_type !== want.frame_type
                        || got.status !== want.status
                        || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d exp %02h/%02h/%0d/%0b got %02h/%02h/%0d/%0b",
                                     $time, results_checked, want.payload_byte,
                                     want.frame_type, want.status, want.last,
                                     got.payload_byte, got.frame_type, got.status,
                                     got.last);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (deframe_predict(data_byte, buffer_start, want))
                begin
                    expected_results.push_back(want);
                    if (want.status == wsdf_pkg::ST_EMPTY)
                        empty_markers++;
                    if (want.status == wsdf_pkg::ST_DROPPED)
                        dropped_frames++;
                end
            end

            // Watchdog: a hung handshake ends the run as a failure.
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d cycles without a request moving",
                         WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    // Directed bytes, {buffer_start, data_byte}: stray bytes before any buffer,
    // a non-frame buffer, a one-byte unmasked frame with trailing junk, masked
    // and unmasked empty frames, both forms of the 64-bit length code, a
    // masked frame with a 16-bit length, and a frame cut short by the next
    // buffer start.
    logic [8:0] directed_bytes[$] = '{
        9'h0A5, 9'h000,
        9'h17F, 9'h081, 9'h0FF,
        9'h181, 9'h001, 9'h0FF, 9'h033,
        9'h18A, 9'h080, 9'h0DE, 9'h0AD, 9'h0BE, 9'h0EF,
        9'h189, 9'h000,
        9'h188, 9'h0FF, 9'h055,
        9'h180, 9'h07F,
        9'h1FF, 9'h0FE, 9'h000, 9'h002, 9'h001, 9'h002, 9'h004, 9'h008, 9'h000, 9'h0FF,
        9'h182, 9'h07D, 9'h011
    };

    initial
    begin
        int unsigned pick;
        int unsigned len;
        int unsigned sent;
        bit          masked;
        bit          ext;

        foreach (directed_bytes[i])
            byte_queue.push_back(directed_bytes[i]);

        while (frame_bytes < RANDOM_BYTES)
        begin
            pick   = $urandom_range(99);
            masked = 1'($urandom_range(1));
            if (pick < 7)
            begin
                // Non-frame buffer: first byte has its FIN bit clear.
                push_byte(1'b1, 8'($urandom_range(127)));
                repeat ($urandom_range(4)) push_byte(1'b0, 8'($urandom));
            end
            else if (pick < 11)
            begin
                // Header broken off early by the next buffer start.
                push_byte(1'b1, 8'h80 | 8'($urandom_range(127)));
                if ($urandom_range(1))
                begin
                    push_byte(1'b0, {masked, wsdf_pkg::LEN_EXT16});
                    if ($urandom_range(1))
                        push_byte(1'b0, 8'($urandom));
                end
            end
            else if (pick < 17)
            begin
                // Unsupported 64-bit length, followed by bytes to be ignored.
                push_byte(1'b1, 8'h80 | 8'($urandom_range(127)));
                push_byte(1'b0, {masked, wsdf_pkg::LEN_EXT64});
                repeat ($urandom_range(3)) push_byte(1'b0, 8'($urandom));
                frame_bytes  += 2;
                frames_built += 1;
            end
            else
            begin
                // Well-formed frame with random content.
                pick = $urandom_range(99);
                ext  = 1'b1;
                if (pick < 12)
                begin
                    len = 0;
                    ext = 1'b0;
                end
                else if (pick < 70)
                begin
                    len = $urandom_range(1, 20);
                    ext = 1'b0;
                end
                else if (pick < 84)
                    len = $urandom_range(0, 40);
                else if (pick < 92)
                    len = $urandom_range(126, 300);
                else
                    len = $urandom_range(65535);
                // Very long frames are always cut; others only now and then.
                if (len > 300)
                    sent = $urandom_range(0, 40);
                else if (len != 0 && $urandom_range(99) < 10)
                    sent = $urandom_range(0, len - 1);
                else
                    sent = len;
                queue_frame(8'h80 | 8'($urandom_range(127)), masked, len, ext, sent,
                            ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes covering %0d frames plus noise buffers and cut headers.",
                 bytes_issued, frames_built);
        $display("Checked %0d results, %0d empty-frame markers and %0d dropped frames.",
                 results_checked, empty_markers, dropped_frames);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
